// ----- rtl/core/swsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared types, constants and microcode encodings of the spill window
// scheduler.
// ----------------------------------------------------------------------------
package swsc_pkg;

  localparam int unsigned MaxBatchesDef = 16;
  localparam int unsigned TimeW         = 64;
  localparam int unsigned SecW          = 32;
  localparam int unsigned CountW        = 5;
  localparam int unsigned HalfW         = 32;
  localparam int unsigned StatW         = 2;
  localparam int unsigned PcW           = 4;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned DivCntW       = $clog2(TimeW);

  localparam logic [TimeW-1:0]  MsLimit       = 64'd4294968;
  localparam logic [CountW-1:0] BatchesReset  = 5'd8;
  localparam logic [HalfW-1:0]  HalfReset     = 32'd21474836;

  localparam logic [CfgIdxW-1:0] CfgBatchesAhead = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHalfWidth    = 1'b1;

  localparam logic [PcW-1:0] StepLoad       = 4'd0;
  localparam logic [PcW-1:0] StepCheck      = 4'd1;
  localparam logic [PcW-1:0] StepDivInit    = 4'd2;
  localparam logic [PcW-1:0] StepDivLoop    = 4'd3;
  localparam logic [PcW-1:0] StepCentre     = 4'd4;
  localparam logic [PcW-1:0] StepEmit       = 4'd5;
  localparam logic [PcW-1:0] StepEmitDone   = 4'd6;
  localparam logic [PcW-1:0] StepStatus     = 4'd7;
  localparam logic [PcW-1:0] StepStatusDone = 4'd8;

  typedef enum logic [StatW-1:0] {
    STAT_WINDOW      = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_NO_DATA     = 2'd2,
    STAT_ZERO_PERIOD = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CENTRE,
    OP_EMIT,
    OP_STATUS
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SPECIAL,
    C_BELOW,
    C_DIV_BUSY,
    C_EMIT_AGAIN,
    C_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic special;
    logic below;
    logic div_busy;
    logic out_free;
    logic last_win;
  } flags_t;

  typedef struct packed {
    logic [CountW-1:0] queued_count;
    logic [TimeW-1:0]  last_end_time;
    logic [SecW-1:0]   approx_seconds;
    logic [TimeW-1:0]  last_spill_time;
    logic [TimeW-1:0]  spill_period;
  } req_t;

  typedef struct packed {
    logic [TimeW-1:0] window_start;
    logic [TimeW-1:0] window_end;
    logic [StatW-1:0] status;
    logic             data_missed;
    logic             last;
  } win_t;

endpackage

// ----- rtl/core/spill_window_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spill_window_scheduler_core
// Plans acquisition windows centered on predicted spills, run by a small
// microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  in      | input     | valid / ready    | swsc_pkg::req_t
//  out     | output    | valid / ready    | swsc_pkg::win_t
//  cfg     | input     | write enable     | index, 32-bit data
//
// A request runs load, check, divide setup, a serial remainder loop over all
// 64 dividend bits, the first center, one emit step per window and a closing
// step. A basis earlier than the last spill skips the divide and the first
// center. A status-only request runs load, check, status and a closing step.
// Output stalls hold the sequencer on its emit or status step.
// Reset clears the step counter and the output valid and loads config defaults.
// ----------------------------------------------------------------------------
module spill_window_scheduler_core #(
  parameter int unsigned MAX_BATCHES = swsc_pkg::MaxBatchesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  swsc_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output swsc_pkg::win_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [swsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swsc_pkg::CfgDataW-1:0] cfg_data_i
);
  import swsc_pkg::*;

  logic [PcW-1:0]    pc_q, pc_d;
  ctrl_t             ctrl;
  flags_t            flags;
  logic              take;
  logic [CountW-1:0] batches_ahead_q;
  logic [HalfW-1:0]  half_width_q;

  swsc_ucode_rom u_rom (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  swsc_datapath #(
    .MAX_BATCHES (MAX_BATCHES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (ctrl.op),
    .in_valid_i      (in_valid_i),
    .req_i           (in_data_i),
    .batches_ahead_i (batches_ahead_q),
    .half_width_i    (half_width_q),
    .out_ready_i     (out_ready_i),
    .flags_o         (flags),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o)
  );

  always_comb begin
    case (ctrl.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !in_valid_i;
      C_SPECIAL:     take = flags.special;
      C_BELOW:       take = flags.below;
      C_DIV_BUSY:    take = flags.div_busy;
      C_EMIT_AGAIN:  take = !flags.out_free || !flags.last_win;
      C_OUT_BLOCKED: take = !flags.out_free;
      default:       take = 1'b1;
    endcase
    pc_d = take ? ctrl.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepLoad;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batches_ahead_q <= BatchesReset;
      half_width_q    <= HalfReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBatchesAhead: batches_ahead_q <= cfg_data_i[CountW-1:0];
        CfgHalfWidth:    half_width_q    <= cfg_data_i[HalfW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = ctrl.op == OP_LOAD;

endmodule

// ----- rtl/core/swsc_ucode_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_ucode_rom
// Read-only control store holding the scheduling program, one control word
// per step.
// ----------------------------------------------------------------------------
module swsc_ucode_rom (
  input  logic [swsc_pkg::PcW-1:0] pc_i,
  output swsc_pkg::ctrl_t          ctrl_o
);
  import swsc_pkg::*;

  always_comb begin
    case (pc_i)
      StepLoad:       ctrl_o = '{op: OP_LOAD,     cond: C_NO_INPUT,    target: StepLoad};
      StepCheck:      ctrl_o = '{op: OP_CHECK,    cond: C_SPECIAL,     target: StepStatus};
      StepDivInit:    ctrl_o = '{op: OP_DIV_INIT, cond: C_BELOW,       target: StepEmit};
      StepDivLoop:    ctrl_o = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,    target: StepDivLoop};
      StepCentre:     ctrl_o = '{op: OP_CENTRE,   cond: C_NEVER,       target: StepLoad};
      StepEmit:       ctrl_o = '{op: OP_EMIT,     cond: C_EMIT_AGAIN,  target: StepEmit};
      StepEmitDone:   ctrl_o = '{op: OP_NONE,     cond: C_ALWAYS,      target: StepLoad};
      StepStatus:     ctrl_o = '{op: OP_STATUS,   cond: C_OUT_BLOCKED, target: StepStatus};
      StepStatusDone: ctrl_o = '{op: OP_NONE,     cond: C_ALWAYS,      target: StepLoad};
      default:        ctrl_o = '{op: OP_NONE,     cond: C_ALWAYS,      target: StepLoad};
    endcase
  end

endmodule

// ----- rtl/core/swsc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_datapath
// Request registers, serial remainder unit, window arithmetic and output
// register, driven by the current control word.
// ----------------------------------------------------------------------------
module swsc_datapath #(
  parameter int unsigned MAX_BATCHES = swsc_pkg::MaxBatchesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swsc_pkg::op_e               op_i,
  input  logic                        in_valid_i,
  input  swsc_pkg::req_t              req_i,
  input  logic [swsc_pkg::CountW-1:0] batches_ahead_i,
  input  logic [swsc_pkg::HalfW-1:0]  half_width_i,
  input  logic                        out_ready_i,
  output swsc_pkg::flags_t            flags_o,
  output logic                        out_valid_o,
  output swsc_pkg::win_t              out_data_o
);
  import swsc_pkg::*;

  localparam int unsigned CapW     = CountW + 1;
  localparam int unsigned CountMax = (1 << CountW) - 1;
  localparam int unsigned CapLimit = (MAX_BATCHES > CountMax) ? CountMax : MAX_BATCHES;
  localparam logic [CapW-1:0] MaxCap = CapW'(CapLimit);
  localparam logic [TimeW-1:0] AllOnes = '1;

  logic [TimeW-1:0]   basis_q, spill_q, period_q, dvd_q, rem_q, centre_q;
  logic [CountW-1:0]  queued_q;
  logic               missed_q;
  status_e            stat_q;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  win_t               out_q;

  logic [TimeW-1:0]  basis_ld;
  logic [CountW-1:0] target;
  logic              full, no_data, zero_period;
  status_e           stat_d;
  logic [TimeW:0]    rem_sh, rem_sub;
  logic [TimeW-1:0]  rem_d;
  logic [TimeW:0]    first_sum, end_sum, step_sum;
  logic [TimeW-1:0]  hw64, win_start, win_end, centre_d;
  logic [CountW-1:0] queued_inc;
  logic              out_free, last_win;

  always_comb begin
    basis_ld = {req_i.approx_seconds, {(TimeW-SecW){1'b0}}};
    if ({1'b0, batches_ahead_i} > MaxCap) begin
      target = MaxCap[CountW-1:0];
    end else begin
      target = batches_ahead_i;
    end
    full        = queued_q >= target;
    no_data     = basis_q < MsLimit;
    zero_period = period_q == '0;
    if (full) begin
      stat_d = STAT_FULL;
    end else if (no_data) begin
      stat_d = STAT_NO_DATA;
    end else if (zero_period) begin
      stat_d = STAT_ZERO_PERIOD;
    end else begin
      stat_d = STAT_WINDOW;
    end

    rem_sh  = {rem_q, dvd_q[TimeW-1]};
    rem_sub = rem_sh - {1'b0, period_q};
    rem_d   = rem_sub[TimeW] ? rem_sh[TimeW-1:0] : rem_sub[TimeW-1:0];

    first_sum = {1'b0, basis_q - rem_q} + {1'b0, period_q};
    hw64      = {{(TimeW-HalfW){1'b0}}, half_width_i};
    win_start = (centre_q >= hw64) ? centre_q - hw64 : '0;
    end_sum   = {1'b0, centre_q} + {1'b0, hw64};
    win_end   = end_sum[TimeW] ? AllOnes : end_sum[TimeW-1:0];
    step_sum  = {1'b0, centre_q} + {1'b0, period_q};
    centre_d  = step_sum[TimeW] ? AllOnes : step_sum[TimeW-1:0];

    queued_inc = queued_q + CountW'(1);
    last_win   = queued_inc == target;
    out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        if (in_valid_i) begin
          queued_q <= req_i.queued_count;
          spill_q  <= req_i.last_spill_time;
          period_q <= req_i.spill_period;
          if (req_i.queued_count != '0 && req_i.last_end_time >= basis_ld) begin
            basis_q <= req_i.last_end_time;
          end else begin
            basis_q <= basis_ld;
          end
          missed_q <= (req_i.queued_count != '0) && (req_i.last_end_time < basis_ld);
        end
      end
      OP_CHECK: begin
        stat_q <= stat_d;
      end
      OP_DIV_INIT: begin
        dvd_q    <= basis_q - spill_q;
        rem_q    <= '0;
        cnt_q    <= '0;
        centre_q <= spill_q;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[TimeW-2:0], 1'b0};
        cnt_q <= cnt_q + DivCntW'(1);
      end
      OP_CENTRE: begin
        centre_q <= first_sum[TimeW] ? AllOnes : first_sum[TimeW-1:0];
      end
      OP_EMIT: begin
        if (out_free) begin
          out_q.window_start <= win_start;
          out_q.window_end   <= win_end;
          out_q.status       <= STAT_WINDOW;
          out_q.data_missed  <= missed_q;
          out_q.last         <= last_win;
          queued_q           <= queued_inc;
          centre_q           <= centre_d;
        end
      end
      OP_STATUS: begin
        if (out_free) begin
          out_q.window_start <= '0;
          out_q.window_end   <= '0;
          out_q.status       <= stat_q;
          out_q.data_missed  <= (stat_q == STAT_FULL) ? 1'b0 : missed_q;
          out_q.last         <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((op_i == OP_EMIT || op_i == OP_STATUS) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign flags_o.special  = full || no_data || zero_period;
  assign flags_o.below    = basis_q < spill_q;
  assign flags_o.div_busy = cnt_q != DivCntW'(TimeW - 1);
  assign flags_o.out_free = out_free;
  assign flags_o.last_win = last_win;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/spill_window_scheduler_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_window_checker
// Watches the request and window channels of the spill window scheduler,
// keeps its own copy of the two configuration registers, plans the windows
// each accepted request should produce and compares every window transfer
// field by field with the oldest planned one. The number of failures and the
// number of windows still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module swsc_window_checker #(
  parameter int unsigned MAX_BATCHES = swsc_pkg::MaxBatchesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  swsc_pkg::req_t                in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  swsc_pkg::win_t                out_data_i,
  input  logic                          cfg_we_i,
  input  logic [swsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swsc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import swsc_pkg::*;

  logic [CountW-1:0] batches_cfg;
  logic [HalfW-1:0]  half_cfg;
  win_t              windows_due[$];

  function automatic void due_add(input win_t w);
    windows_due = {windows_due, w};
  endfunction

  function automatic logic [TimeW-1:0] sat_sum(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] sat_prod(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    logic [2*TimeW-1:0] p;
    p = {{TimeW{1'b0}}, a} * {{TimeW{1'b0}}, b};
    return (|p[2*TimeW-1:TimeW]) ? '1 : p[TimeW-1:0];
  endfunction

  function automatic win_t status_item(input status_e code, input logic missed);
    win_t w;
    w.window_start = '0;
    w.window_end   = '0;
    w.status       = code;
    w.data_missed  = missed;
    w.last         = 1'b1;
    return w;
  endfunction

  function automatic void plan_windows(input req_t req);
    int unsigned      goal;
    int unsigned      filled;
    logic [TimeW-1:0] basis;
    logic [TimeW-1:0] coef;
    logic [TimeW-1:0] centre;
    logic [TimeW-1:0] half;
    logic             missed;
    win_t             w;
    goal   = (32'(batches_cfg) > MAX_BATCHES) ? MAX_BATCHES : 32'(batches_cfg);
    filled = 32'(req.queued_count);
    half   = {{(TimeW-HalfW){1'b0}}, half_cfg};
    missed = 1'b0;
    basis  = {req.approx_seconds, {(TimeW-SecW){1'b0}}};
    if (filled >= goal) begin
      due_add(status_item(STAT_FULL, 1'b0));
      return;
    end
    if (filled != 0) begin
      if (req.last_end_time >= basis) begin
        basis = req.last_end_time;
      end else begin
        missed = 1'b1;
      end
    end
    if (basis < MsLimit) begin
      due_add(status_item(STAT_NO_DATA, missed));
      return;
    end
    if (req.spill_period == '0) begin
      due_add(status_item(STAT_ZERO_PERIOD, missed));
      return;
    end
    if (basis < req.last_spill_time) begin
      coef = '0;
    end else begin
      coef = sat_sum((basis - req.last_spill_time) / req.spill_period, 64'd1);
    end
    while (filled < goal) begin
      centre         = sat_sum(req.last_spill_time, sat_prod(req.spill_period, coef));
      w.window_start = (centre >= half) ? centre - half : '0;
      w.window_end   = sat_sum(centre, half);
      w.status       = STAT_WINDOW;
      w.data_missed  = missed;
      filled++;
      w.last         = (filled == goal);
      due_add(w);
      coef = sat_sum(coef, 64'd1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    win_t want;
    if (!rst_ni) begin
      batches_cfg  = BatchesReset;
      half_cfg     = HalfReset;
      fail_count_o = 0;
      windows_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgBatchesAhead) begin
          batches_cfg = cfg_data_i[CountW-1:0];
        end else if (cfg_index_i == CfgHalfWidth) begin
          half_cfg = cfg_data_i[HalfW-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        plan_windows(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (windows_due.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: window transfer with nothing due: start %h end %h status %0d",
                     $realtime, out_data_i.window_start, out_data_i.window_end,
                     out_data_i.status);
          end
          fail_count_o++;
        end else begin
          want = windows_due.pop_front();
          if (out_data_i !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: window mismatch", $realtime);
              $display("  start    expected %h actual %h",
                       want.window_start, out_data_i.window_start);
              $display("  end      expected %h actual %h",
                       want.window_end, out_data_i.window_end);
              $display("  status   expected %0d actual %0d",
                       want.status, out_data_i.status);
              $display("  missed   expected %b actual %b",
                       want.data_missed, out_data_i.data_missed);
              $display("  last     expected %b actual %b",
                       want.last, out_data_i.last);
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_o = windows_due.size();
  end

endmodule

// ----- tb/tb_spill_window_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spill_window_scheduler_core
// Drives requests and configuration writes into the spill window scheduler
// and toggles the window receiver, with a directed part for the boundary
// cases followed by random requests under three idling patterns and one
// long receiver hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_spill_window_scheduler_core;
  import swsc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongHold   = 600;
  localparam int unsigned SettleWait = 12;

  logic                clk_i     = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  req_t                in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  win_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int                  fail_count;
  int                  pending;
  int unsigned         send_idle_pct = 17;
  int unsigned         recv_idle_pct = 86;
  logic                long_hold_req = 1'b0;
  logic [CountW-1:0]   cur_batches   = BatchesReset;
  int unsigned         cycle_count   = 0;

  always #5 clk_i = ~clk_i;

  spill_window_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  swsc_window_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("spill_window_scheduler_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t mk(input logic [CountW-1:0] queued,
                              input logic [TimeW-1:0]  last_end,
                              input logic [SecW-1:0]   secs,
                              input logic [TimeW-1:0]  spill,
                              input logic [TimeW-1:0]  period);
    req_t r;
    r.queued_count    = queued;
    r.last_end_time   = last_end;
    r.approx_seconds  = secs;
    r.last_spill_time = spill;
    r.spill_period    = period;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t             r;
    int unsigned      goal;
    int unsigned      pick;
    logic [TimeW-1:0] basis;
    goal = (32'(cur_batches) > MaxBatchesDef) ? MaxBatchesDef : 32'(cur_batches);
    pick = $urandom_range(0, 9);
    if (pick < 7 && goal > 0) begin
      r.queued_count = CountW'($urandom_range(0, goal - 1));
    end else if (pick < 9) begin
      r.queued_count = CountW'($urandom_range(goal, MaxBatchesDef));
    end else begin
      r.queued_count = CountW'($urandom_range(0, 31));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      r.approx_seconds = '0;
    end else if (pick < 3) begin
      r.approx_seconds = $urandom_range(0, 1000);
    end else begin
      r.approx_seconds = $urandom;
    end
    basis = {r.approx_seconds, 32'h0};
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      r.last_end_time = basis + {30'h0, 2'($urandom_range(0, 3)), $urandom};
    end else if (pick < 5) begin
      r.last_end_time = basis - {30'h0, 2'($urandom_range(0, 3)), $urandom};
    end else if (pick < 6) begin
      r.last_end_time = {32'h0, $urandom_range(0, 9_000_000)};
    end else begin
      r.last_end_time = rand64();
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      r.last_spill_time = basis - {28'h0, 4'($urandom_range(0, 15)), $urandom};
    end else if (pick < 7) begin
      r.last_spill_time = basis + {30'h0, 2'($urandom_range(0, 3)), $urandom};
    end else if (pick < 8) begin
      r.last_spill_time = '0;
    end else begin
      r.last_spill_time = rand64();
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      r.spill_period = {30'h0, 2'($urandom_range(0, 3)), $urandom};
    end else if (pick < 7) begin
      r.spill_period = '0;
    end else if (pick < 8) begin
      r.spill_period = '1;
    end else begin
      r.spill_period = rand64();
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CfgBatchesAhead) begin
      cur_batches = value[CountW-1:0];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(posedge clk_i);
    end while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_request(random_request());
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    send_request(mk(5'd8, 64'd0, 32'd100, 64'd0, 64'h1_0000_0000));
    send_request(mk('1, '1, '1, '1, '1));
    send_request(mk(5'd0, '1, 32'd0, 64'd0, 64'h1_0000_0000));
    send_request(mk(5'd3, MsLimit - 64'd1, 32'd0, 64'd0, 64'd1));
    send_request(mk(5'd3, MsLimit, 32'd0, 64'd0, 64'd1000));
    send_request(mk(5'd2, 64'h5_0000_0000, 32'd10, 64'h4_8000_0000, 64'd0));
    send_request(mk(5'd0, 64'd0, 32'd10, 64'h9_0000_0000, 64'd0));
    send_request(mk(5'd5, 64'hA_0000_0000, 32'd10, 64'h9_8000_0000, 64'h4000_0000));
    send_request(mk(5'd7, 64'd0, 32'd1000, 64'h7D0_0000_0000, 64'h1_0000_0000));
    send_request(mk(5'd4, 64'd100, 32'd3600, 64'hE0F_8000_0000, 64'h1_6666_6666));
    send_request(mk(5'd6, '1, '1, '1, '1));
    send_request(mk(5'd0, 64'd0, '1, 64'd0, '1));
    send_request(mk(5'd1, 64'd5_000_000, 32'd0, 64'd10_000_000, 64'd1));
    drain();

    write_reg(CfgBatchesAhead, ($urandom & 32'hFFFF_FFE0) | 32'd16);
    write_reg(CfgHalfWidth, 32'd0);
    send_request(mk(5'd0, 64'd0, 32'd50, 64'h31_0000_0000, 64'd1));
    send_request(mk(5'd15, 64'd0, 32'd50, 64'h30_0000_0000, 64'h1_0000_0000));
    send_request(mk(5'd16, 64'd0, 32'd50, 64'h30_0000_0000, 64'h1_0000_0000));
    drain();

    write_reg(CfgBatchesAhead, 32'd0);
    send_request(mk(5'd0, 64'd0, 32'd50, 64'h30_0000_0000, 64'h1_0000_0000));
    drain();

    write_reg(CfgBatchesAhead, 32'd31);
    write_reg(CfgHalfWidth, 32'hFFFF_FFFF);
    send_request(mk(5'd0, 64'd0, 32'd2, 64'h1_0000_0000, 64'h8000_0000));
    send_request(mk(5'd10, MsLimit, 32'd0, 64'd1, 64'd1));
    send_request(mk(5'd0, 64'd0, '1, '1, 64'd1));
    drain();

    write_reg(CfgBatchesAhead, 32'd1);
    write_reg(CfgHalfWidth, HalfReset);
    send_request(mk(5'd0, 64'd0, 32'h8000_0000, 64'h7FFF_FFF0_0000_0000, 64'h10_0000));
    drain();

    write_reg(CfgBatchesAhead, ($urandom & 32'hFFFF_FFE0) | 32'd8);
    write_reg(CfgHalfWidth, $urandom_range(0, 32'h1000_0000));
    long_hold_req = 1'b1;
    send_random(30);

    send_idle_pct = 86;
    recv_idle_pct = 17;
    write_reg(CfgBatchesAhead, $urandom_range(1, 16));
    write_reg(CfgHalfWidth, $urandom);
    send_random(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgBatchesAhead, 32'd31);
    write_reg(CfgHalfWidth, 32'hFFFF_FFFF);
    send_random(10);
    write_reg(CfgBatchesAhead, $urandom_range(0, 31));
    write_reg(CfgHalfWidth, $urandom_range(0, 50_000_000));
    send_random(10);

    if (fail_count == 0) begin
      $display("spill_window_scheduler_core regression: pass");
    end else begin
      $display("spill_window_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/swsc_pkg.sv
rtl/core/swsc_ucode_rom.sv
rtl/core/swsc_datapath.sv
rtl/core/spill_window_scheduler_core.sv
tb/spill_window_scheduler_checker.sv
tb/tb_spill_window_scheduler_core.sv
